// ----- src/rtet_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rtet_pkg;
	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_TICK   = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic        valid;
		logic [15:0] id;
		logic [31:0] key_time;
		logic [31:0] next_time;
		logic [15:0] repeats_left;
		logic [31:0] interval;
		logic [15:0] fire_count;
	} entry_t;

	// latched when a request is accepted and held while the request is processed
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] id;
		logic [31:0] start_time;
		logic [15:0] repeat_count;
		logic [31:0] interval;
		logic [31:0] elapsed;
	} rtet_cmd_t;

	typedef struct packed {
		logic        fired;
		logic [15:0] fired_id;
		logic [15:0] fire_index;
		logic        add_rejected;
		logic        last;
	} rtet_res_t;
endpackage
`default_nettype wire

// ----- src/rtet_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rtet_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] event_id;
	logic [31:0] start_time;
	logic [15:0] repeat_count;
	logic [31:0] repeat_interval;
	logic [15:0] delta_time;
	modport source (output valid, req_type, event_id, start_time, repeat_count,
		repeat_interval, delta_time, input ready);
	modport sink (input valid, req_type, event_id, start_time, repeat_count,
		repeat_interval, delta_time, output ready);
endinterface

interface rtet_res_if;
	logic        valid;
	logic        ready;
	logic        fired;
	logic [15:0] fired_id;
	logic [15:0] fire_index;
	logic        add_rejected;
	logic        last;
	modport source (output valid, fired, fired_id, fire_index, add_rejected, last,
		input ready);
	modport sink (input valid, fired, fired_id, fire_index, add_rejected, last,
		output ready);
endinterface
`default_nettype wire

// ----- src/rtet_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// one table slot; the slot at the head of the ring is processed as it shifts out
module rtet_cell import rtet_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   shift,
	input  wire logic   clr,
	input  wire entry_t din,
	output entry_t      dout
);
	logic        valid_q;
	logic [15:0] id_q;
	logic [31:0] key_time_q;
	logic [31:0] next_time_q;
	logic [15:0] repeats_left_q;
	logic [31:0] interval_q;
	logic [15:0] fire_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= din.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (shift) begin
			id_q           <= din.id;
			key_time_q     <= din.key_time;
			next_time_q    <= din.next_time;
			repeats_left_q <= din.repeats_left;
			interval_q     <= din.interval;
			fire_count_q   <= din.fire_count;
		end
	end
	assign dout = '{valid_q, id_q, key_time_q, next_time_q, repeats_left_q, interval_q,
		fire_count_q};
endmodule
`default_nettype wire

// ----- src/rtet_head.sv -----
`timescale 1ns / 1ps
`default_nettype none
// processes the entry leaving the ring and forms its replacement
module rtet_head import rtet_pkg::*; (
	input  wire entry_t    ein,
	input  wire rtet_cmd_t cmd,
	input  wire logic      add_done,
	input  wire logic      is_lastslot,
	output entry_t         eout,
	output logic           fire,
	output logic           store
);
	logic [32:0] adv;
	logic        match, hit;
	always_comb begin
		eout  = ein;
		fire  = 1'b0;
		store = 1'b0;
		adv   = {1'b0, ein.next_time} + {1'b0, ein.interval};
		match = ein.valid && ein.id == cmd.id && ein.key_time == cmd.start_time;
		hit   = ein.valid && ein.next_time < cmd.elapsed;
		case (cmd.op)
			REQ_ADD: begin
				// first pass finds a match; a later free slot wins only if none matched
				if (!add_done && (match || (!ein.valid && is_lastslot))) store = 1'b1;
			end
			REQ_TICK: begin
				if (hit) begin
					fire = 1'b1;
					if (ein.fire_count != 16'hFFFF) eout.fire_count = ein.fire_count + 16'd1;
					if (ein.repeats_left != 16'd0) begin
						eout.repeats_left = ein.repeats_left - 16'd1;
						eout.next_time = adv[32] ? 32'hFFFF_FFFF : adv[31:0];
					end else begin
						eout.valid = 1'b0;
					end
				end
			end
			default: ;
		endcase
		if (store) begin
			eout.valid        = 1'b1;
			eout.id           = cmd.id;
			eout.key_time     = cmd.start_time;
			eout.next_time    = cmd.start_time;
			eout.repeats_left = cmd.repeat_count;
			eout.interval     = cmd.interval;
			eout.fire_count   = 16'd0;
		end
	end
endmodule
`default_nettype wire

// ----- src/repeating_timer_event_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel  role    content
// req      sink    req_type, event_id, start_time, repeat_count, repeat_interval, delta_time
// res      source  fired, fired_id, fire_index, add_rejected, last
//
// slots form a ring of cells; one rotation visits each slot once at the head
// tick: one rotation
// add: match search rotation, which is all on overwrite, else a second rotation for
// the lowest free slot; a locked add goes straight to its rejected result
// clear, unused codes skip the ring; reset empties the table at once
// the ring halts while a result waits untaken in the output register
module repeating_timer_event_table import rtet_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	rtet_req_if.sink   req,
	rtet_res_if.source res
);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [1:0] ST_IDLE = 2'd0, ST_RUN = 2'd1, ST_OUT = 2'd2;

	logic [1:0]  state_q;
	logic [CW-1:0] cnt_q;
	logic        pass_q, done_q, locked_q;
	logic [31:0] elapsed_q;
	rtet_cmd_t   cmd_q;
	rtet_res_t   res_q;
	rtet_res_t   pend_q;
	logic        rv_q;
	logic        pv_q;
	logic        shift, clr, fire, store, lastslot_pass;
	logic        ld_fire, ld_close;
	entry_t      ring [ENTRIES];
	entry_t      head_out;

	assign lastslot_pass = pass_q;
	assign req.ready = state_q == ST_IDLE;
	wire accept = req.valid && req.ready;
	wire stall = rv_q && !res.ready;
	assign shift = state_q == ST_RUN && !stall && cnt_q != CW'(ENTRIES);
	assign clr = accept && req.req_type == REQ_CLEAR;
	// a held firing moves to the output when the next one arrives
	assign ld_fire  = shift && fire && pv_q;
	assign ld_close = state_q == ST_OUT && !stall;

	rtet_head u_head (.ein(ring[0]), .cmd(cmd_q), .add_done(done_q),
		.is_lastslot(lastslot_pass), .eout(head_out), .fire(fire), .store(store));

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		entry_t din;
		if (g == ENTRIES - 1) begin : g_tail
			assign din = head_out;
		end else begin : g_mid
			assign din = ring[g+1];
		end
		rtet_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift), .clr(clr),
			.din(din), .dout(ring[g]));
	end

	logic [32:0] enew;
	assign enew = {1'b0, elapsed_q} + {17'd0, req.delta_time};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			pass_q    <= 1'b0;
			done_q    <= 1'b0;
			locked_q  <= 1'b0;
			elapsed_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) begin
					cnt_q <= '0; pass_q <= 1'b0; done_q <= 1'b0;
					case (req.req_type)
						REQ_ADD: state_q <= locked_q ? ST_OUT : ST_RUN;
						REQ_TICK: begin
							locked_q <= 1'b1;
							elapsed_q <= enew[32] ? 32'hFFFF_FFFF : enew[31:0];
							state_q <= ST_RUN;
						end
						REQ_CLEAR: begin
							locked_q <= 1'b0; elapsed_q <= '0; state_q <= ST_OUT;
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_RUN: if (!stall) begin
					if (shift) begin
						cnt_q <= cnt_q + CW'(1);
						if (store) done_q <= 1'b1;
					end else if (cmd_q.op == REQ_ADD && !pass_q && !done_q) begin
						pass_q <= 1'b1; cnt_q <= '0;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: if (!stall) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_q <= 1'b0;
		else if (ld_fire || ld_close) rv_q <= 1'b1;
		else if (res.ready) rv_q <= 1'b0;
	end

	// last firing is unknown until the rotation ends, so each firing result is held
	// in pend_q: a new one pushes out the previous with last 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pv_q <= 1'b0;
		else if (shift && fire) pv_q <= 1'b1;
		else if (ld_close) pv_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op <= req.req_type; cmd_q.id <= req.event_id;
			cmd_q.start_time <= req.start_time; cmd_q.repeat_count <= req.repeat_count;
			cmd_q.interval <= req.repeat_interval;
			cmd_q.elapsed <= enew[32] ? 32'hFFFF_FFFF : enew[31:0];
		end
		if (shift && fire) begin
			pend_q <= '{1'b1, ring[0].id, ring[0].fire_count, 1'b0, 1'b0};
		end
		if (ld_fire) begin
			res_q <= '{1'b1, pend_q.fired_id, pend_q.fire_index, 1'b0, 1'b0};
		end else if (ld_close) begin
			if (pv_q) res_q <= '{1'b1, pend_q.fired_id, pend_q.fire_index, 1'b0, 1'b1};
			else res_q <= '{1'b0, 16'd0, 16'd0,
				cmd_q.op == REQ_ADD && !done_q, 1'b1};
		end
	end

	assign res.valid        = rv_q;
	assign res.fired        = res_q.fired;
	assign res.fired_id     = res_q.fired_id;
	assign res.fire_index   = res_q.fire_index;
	assign res.add_rejected = res_q.add_rejected;
	assign res.last         = res_q.last;

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !req.ready) else $error("ready while busy");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(ENTRIES)) else $error("slot count overrun");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(res_q)) else $error("result changed while stalled");
	a_vhold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid) else $error("result dropped while stalled");
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import rtet_pkg::*;

	localparam int SLOTS = 16;

	logic clk;
	logic arst_n;

	rtet_req_if req ();
	rtet_res_if res ();

	repeating_timer_event_table #(.ENTRIES(SLOTS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.res(res.source)
	);

	typedef struct {
		logic [1:0]  op;
		logic [15:0] id;
		logic [31:0] start;
		logic [15:0] reps;
		logic [31:0] ivl;
		logic [15:0] delta;
		bit          has_exp;
		logic        exp_rej;
	} stim_t;

	// shadow of the timer table
	logic        sh_valid [SLOTS];
	logic [15:0] sh_id [SLOTS];
	logic [31:0] sh_key [SLOTS];
	logic [31:0] sh_next [SLOTS];
	logic [15:0] sh_reps [SLOTS];
	logic [31:0] sh_ivl [SLOTS];
	logic [15:0] sh_count [SLOTS];
	logic [31:0] sh_elapsed;
	logic        sh_locked;

	rtet_res_t   pending_fires[$];
	int          mismatches;
	bit          hold_long;
	bit          stim_done;
	stim_t       table_rows[$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tb: errors");
		$finish;
	end

	function automatic rtet_res_t mk_res(logic f, logic [15:0] id, logic [15:0] idx,
		logic rej, logic lst);
		rtet_res_t r;
		r.fired = f;
		r.fired_id = id;
		r.fire_index = idx;
		r.add_rejected = rej;
		r.last = lst;
		return r;
	endfunction

	function automatic void queue_res(rtet_res_t r);
		pending_fires = {pending_fires, r};
	endfunction

	// computes the results of one request and updates the shadow table
	task automatic predict_timer(input stim_t s);
		int slot;
		int n;
		logic [32:0] sum;
		slot = -1;
		n = 0;
		case (s.op)
			REQ_ADD: begin
				if (!sh_locked) begin
					for (int i = 0; i < SLOTS; i++)
						if (slot < 0 && sh_valid[i] && sh_id[i] == s.id && sh_key[i] == s.start)
							slot = i;
					for (int i = 0; i < SLOTS; i++)
						if (slot < 0 && !sh_valid[i])
							slot = i;
				end
				if (slot >= 0) begin
					sh_valid[slot] = 1'b1;
					sh_id[slot] = s.id;
					sh_key[slot] = s.start;
					sh_next[slot] = s.start;
					sh_reps[slot] = s.reps;
					sh_ivl[slot] = s.ivl;
					sh_count[slot] = '0;
				end
				queue_res(mk_res(1'b0, 16'd0, 16'd0, slot < 0, 1'b1));
			end
			REQ_TICK: begin
				sh_locked = 1'b1;
				sum = {1'b0, sh_elapsed} + {17'd0, s.delta};
				sh_elapsed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				for (int i = 0; i < SLOTS; i++) begin
					if (sh_valid[i] && sh_next[i] < sh_elapsed) begin
						queue_res(mk_res(1'b1, sh_id[i], sh_count[i], 1'b0, 1'b0));
						n++;
						if (sh_count[i] != 16'hFFFF)
							sh_count[i]++;
						if (sh_reps[i] > 16'd0) begin
							sh_reps[i]--;
							sum = {1'b0, sh_next[i]} + {1'b0, sh_ivl[i]};
							sh_next[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
						end else begin
							sh_valid[i] = 1'b0;
						end
					end
				end
				if (n == 0)
					queue_res(mk_res(1'b0, 16'd0, 16'd0, 1'b0, 1'b1));
				else
					pending_fires[pending_fires.size() - 1].last = 1'b1;
			end
			REQ_CLEAR: begin
				for (int i = 0; i < SLOTS; i++)
					sh_valid[i] = 1'b0;
				sh_elapsed = '0;
				sh_locked = 1'b0;
				queue_res(mk_res(1'b0, 16'd0, 16'd0, 1'b0, 1'b1));
			end
			default: begin
				queue_res(mk_res(1'b0, 16'd0, 16'd0, 1'b0, 1'b1));
			end
		endcase
	endtask

	task automatic send_req(input stim_t s);
		rtet_res_t r;
		@(negedge clk);
		req.valid <= 1'b1;
		req.req_type <= s.op;
		req.event_id <= s.id;
		req.start_time <= s.start;
		req.repeat_count <= s.reps;
		req.repeat_interval <= s.ivl;
		req.delta_time <= s.delta;
		do @(posedge clk); while (!req.ready);
		predict_timer(s);
		// rows with a typed-in outcome check the prediction itself
		if (s.has_exp) begin
			r = pending_fires[$];
			if (r.add_rejected !== s.exp_rej) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row reject exp %0b pred %0b", s.exp_rej, r.add_rejected);
			end
		end
		@(negedge clk);
		req.valid <= 1'b0;
	endtask

	function automatic stim_t row(logic [1:0] op, logic [15:0] id, logic [31:0] start,
		logic [15:0] reps, logic [31:0] ivl, logic [15:0] delta, bit he = 1'b0,
		logic rej = 1'b0);
		stim_t s;
		s.op = op; s.id = id; s.start = start; s.reps = reps; s.ivl = ivl;
		s.delta = delta; s.has_exp = he; s.exp_rej = rej;
		return s;
	endfunction

	function automatic stim_t rand_req();
		stim_t s;
		int k;
		k = $urandom_range(0, 99);
		s.has_exp = 0;
		s.exp_rej = 0;
		s.id = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 5));
		s.start = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 400);
		s.reps = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4));
		s.ivl = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 120);
		s.delta = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 150));
		if (k < 55)
			s.op = REQ_ADD;
		else if (k < 85)
			s.op = REQ_TICK;
		else if (k < 97)
			s.op = REQ_CLEAR;
		else
			s.op = REQ_UNUSED;
		return s;
	endfunction

	// result checker
	always @(posedge clk) begin
		rtet_res_t e;
		if (arst_n && res.valid && res.ready) begin
			if (pending_fires.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result fired %0b id %0h", res.fired, res.fired_id);
			end else begin
				e = pending_fires.pop_front();
				if (res.fired !== e.fired || res.fired_id !== e.fired_id ||
					res.fire_index !== e.fire_index || res.add_rejected !== e.add_rejected ||
					res.last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %0b/%0h/%0h/%0b/%0b got %0b/%0h/%0h/%0b/%0b",
							e.fired, e.fired_id, e.fire_index, e.add_rejected, e.last,
							res.fired, res.fired_id, res.fire_index, res.add_rejected, res.last);
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		int pat;
		res.ready = 1'b0;
		pat = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				res.ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_long = 0;
			end
			pat++;
			if (stim_done || (pat % 200) < 60)
				res.ready <= 1'b1;
			else
				res.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		stim_t s;
		int burst;
		int gap;
		mismatches = 0;
		hold_long = 0;
		stim_done = 0;
		for (int i = 0; i < SLOTS; i++) begin
			sh_valid[i] = 0; sh_id[i] = 0; sh_key[i] = 0; sh_next[i] = 0;
			sh_reps[i] = 0; sh_ivl[i] = 0; sh_count[i] = 0;
		end
		sh_elapsed = 0;
		sh_locked = 0;
		req.valid = 1'b0;
		req.req_type = REQ_CLEAR;
		req.event_id = '0;
		req.start_time = '0;
		req.repeat_count = '0;
		req.repeat_interval = '0;
		req.delta_time = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, overwrite, full table, lock, unused code
		table_rows = {table_rows,
			row(REQ_ADD, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, '0, 1'b1, 1'b0)};
		table_rows = {table_rows, row(REQ_ADD, 16'h0000, 32'h0, 16'h0, 32'h0, '0, 1'b1, 1'b0)};
		table_rows = {table_rows, row(REQ_ADD, 16'h0000, 32'h0, 16'h3, 32'h5, '0, 1'b1, 1'b0)};
		for (int i = 2; i < SLOTS; i++)
			table_rows = {table_rows,
				row(REQ_ADD, 16'(i), 32'(i), 16'h2, 32'h7, '0, 1'b1, 1'b0)};
		table_rows = {table_rows,
			row(REQ_ADD, 16'h5555, 32'hAAAA_AAAA, 16'h1, 32'h1, '0, 1'b1, 1'b1)};
		table_rows = {table_rows, row(REQ_TICK, '0, '0, '0, '0, 16'h0)};
		table_rows = {table_rows, row(REQ_ADD, 16'h1, 32'h1, '0, '0, '0, 1'b1, 1'b1)};
		table_rows = {table_rows, row(REQ_TICK, '0, '0, '0, '0, 16'hFFFF)};
		table_rows = {table_rows,
			row(REQ_UNUSED, 16'hAAAA, 32'h5555_5555, 16'h5555, 32'hAAAA_AAAA, 16'hAAAA)};
		for (int i = 0; i < 4; i++)
			table_rows = {table_rows, row(REQ_TICK, '0, '0, '0, '0, 16'hFFFF)};
		table_rows = {table_rows, row(REQ_CLEAR, '0, '0, '0, '0, '0, 1'b1, 1'b0)};
		foreach (table_rows[i])
			send_req(table_rows[i]);

		// many max ticks after a long-lived entry
		send_req(row(REQ_ADD, 16'h00F0, 32'hFFFF_FFF0, 16'h2, 32'hFFFF_FFFF, '0, 1'b1, 1'b0));
		for (int i = 0; i < 8; i++)
			send_req(row(REQ_TICK, '0, '0, '0, '0, 16'hFFFF));
		// pause until drained
		wait (pending_fires.size() == 0);
		send_req(row(REQ_CLEAR, '0, '0, '0, '0, '0, 1'b1, 1'b0));

		// receiver holds off while the sender keeps going
		hold_long = 1;
		for (int i = 0; i < 30; i++)
			send_req(rand_req());

		burst = 0;
		for (int i = 0; i < 100; i++) begin
			if (burst == 0) begin
				gap = $urandom_range(0, 6);
				repeat (gap) @(negedge clk);
				burst = $urandom_range(1, 12);
			end
			burst--;
			s = rand_req();
			send_req(s);
		end
		stim_done = 1;

		fork
			wait (pending_fires.size() == 0);
			begin
				#10ms;
				$display("tb: errors");
				$finish;
			end
		join_any
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_fires.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

// ----- sim.f -----
src/rtet_pkg.sv
src/rtet_if.sv
src/rtet_cell.sv
src/rtet_head.sv
src/repeating_timer_event_table.sv
tb/tb.sv
